/* sv/glcd_dcs_pkg.sv */
// Shared types and codes for the dual-controller graphic LCD cursor sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package glcd_dcs_pkg;

  // Request opcodes
  localparam logic [1:0] OP_SET_ADDR   = 2'd0;
  localparam logic [1:0] OP_DATA_WRITE = 2'd1;
  localparam logic [1:0] OP_DATA_READ  = 2'd2;
  localparam logic [1:0] OP_RAW_CMD    = 2'd3;

  // Bus transaction kinds
  localparam logic [1:0] KIND_SELECT = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // Register indexes (paddr[2])
  localparam logic REG_COLUMN_BASE = 1'b0;
  localparam logic REG_PAGE_BASE   = 1'b1;

  localparam logic [7:0] COLUMN_BASE_RESET = 8'd64;
  localparam logic [7:0] PAGE_BASE_RESET   = 8'd184;

  // Cache code for a page not yet sent
  localparam logic [3:0] PAGE_UNKNOWN = 4'hF;

  localparam int NUM_CHIPS   = 2;
  localparam int MAX_TRANS   = 4;
  // Plan queue depth, power of two
  localparam int QUEUE_DEPTH = 2;

  // One bus transaction
  typedef struct packed {
    logic [1:0] kind;
    logic       chip;
    logic [7:0] data;
  } trans_t;

  // All transactions caused by one item
  typedef struct packed {
    logic [2:0]                 cnt;
    trans_t [MAX_TRANS-1:0]     ent;
  } plan_t;

  // Append one transaction to a plan
  function automatic plan_t add_trans(plan_t p, logic [1:0] kind, logic chip,
                                      logic [7:0] data);
    plan_t r;
    r = p;
    if (p.cnt < 3'(MAX_TRANS)) begin
      r.ent[p.cnt[1:0]].kind = kind;
      r.ent[p.cnt[1:0]].chip = chip;
      r.ent[p.cnt[1:0]].data = data;
      r.cnt = p.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/glcd_dcs_front.sv */
// Front end: accepts requests, keeps chip/cursor/page-cache state, builds transaction plans.
// Depends on glcd_dcs_pkg.
`default_nettype none

module glcd_dcs_front #(
  parameter int CHIP_COLUMNS = 64,
  parameter int PAGES        = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           opcode,
  input  wire logic [6:0]           column,
  input  wire logic [2:0]           page,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 chip_index,
  input  wire logic [7:0]           column_base,
  input  wire logic [7:0]           page_base,
  input  wire logic                 q_full,
  output logic                      q_push,
  output glcd_dcs_pkg::plan_t       q_plan
);

  localparam int TOTAL = glcd_dcs_pkg::NUM_CHIPS * CHIP_COLUMNS;
  localparam int CUR_W = $clog2(TOTAL);

  // Architectural state
  logic             active_chip;
  logic [CUR_W-1:0] cursor;
  logic [2:0]       cursor_page;
  logic [1:0][3:0]  page_cache;

  logic             active_next;
  logic [CUR_W-1:0] cursor_next;
  logic [2:0]       cursor_page_next;
  logic [1:0][3:0]  page_cache_next;

  glcd_dcs_pkg::plan_t plan;

  logic             accept;
  logic [CUR_W-1:0] col_sat;
  logic [2:0]       pg_sat;
  logic             at_end;
  logic             crossing;
  logic             do_col;
  logic             do_page;
  logic [2:0]       pg_val;
  logic             col_chip;
  logic [CUR_W-1:0] in_col;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;
  assign q_plan   = plan;

  // Saturate set-address operands
  always_comb begin
    if ({2'b00, column} >= 9'(TOTAL)) begin
      col_sat = CUR_W'(TOTAL - 1);
    end else begin
      col_sat = CUR_W'(column);
    end
    if ({1'b0, page} >= 4'(PAGES)) begin
      pg_sat = 3'(PAGES - 1);
    end else begin
      pg_sat = page;
    end
  end

  // End of line and controller crossing for data writes
  assign at_end   = 9'(cursor) >= 9'(TOTAL - 1);
  assign crossing = (9'(cursor) + 9'd1) == 9'(CHIP_COLUMNS);

  // Plan and next state
  always_comb begin
    plan             = '0;
    active_next      = active_chip;
    cursor_next      = cursor;
    cursor_page_next = cursor_page;
    page_cache_next  = page_cache;
    do_col           = 1'b0;
    do_page          = 1'b0;
    pg_val           = cursor_page;
    col_chip         = 1'b0;
    in_col           = '0;

    case (opcode)
      glcd_dcs_pkg::OP_SET_ADDR: begin
        cursor_next = col_sat;
        do_col      = 1'b1;
        do_page     = 1'b1;
        pg_val      = pg_sat;
      end
      glcd_dcs_pkg::OP_DATA_WRITE: begin
        plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_WRITE, active_chip,
                                       data_byte);
        if (at_end) begin
          // wrap to the first column of the last controller
          cursor_next = CUR_W'(CHIP_COLUMNS);
        end else begin
          cursor_next = cursor + CUR_W'(1);
          if (crossing) begin
            do_col  = 1'b1;
            do_page = 1'b1;
          end
        end
      end
      glcd_dcs_pkg::OP_DATA_READ: begin
        plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_READ, active_chip, 8'd0);
      end
      default: begin
        if (chip_index != active_chip) begin
          plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_SELECT, chip_index, 8'd0);
          plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_CMD, chip_index,
                                         data_byte);
          plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_SELECT, active_chip,
                                         8'd0);
        end else begin
          plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_CMD, chip_index,
                                         data_byte);
        end
      end
    endcase

    // Select the controller holding the cursor and send its column
    if (do_col) begin
      col_chip = 9'(cursor_next) >= 9'(CHIP_COLUMNS);
      in_col   = col_chip ? (cursor_next - CUR_W'(CHIP_COLUMNS)) : cursor_next;
      if (col_chip != active_next) begin
        active_next = col_chip;
        plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_SELECT, col_chip, 8'd0);
      end
      plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_CMD, active_next,
                                     column_base | 8'(in_col));
    end

    // Send the page only when the cache differs
    if (do_page) begin
      cursor_page_next = pg_val;
      if (page_cache_next[active_next] != {1'b0, pg_val}) begin
        page_cache_next[active_next] = {1'b0, pg_val};
        plan = glcd_dcs_pkg::add_trans(plan, glcd_dcs_pkg::KIND_CMD, active_next,
                                       page_base | {5'd0, pg_val});
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_chip <= 1'b0;
      cursor      <= '0;
      cursor_page <= '0;
      page_cache  <= {glcd_dcs_pkg::PAGE_UNKNOWN, glcd_dcs_pkg::PAGE_UNKNOWN};
    end else if (accept) begin
      active_chip <= active_next;
      cursor      <= cursor_next;
      cursor_page <= cursor_page_next;
      page_cache  <= page_cache_next;
    end
  end

endmodule

`default_nettype wire

/* sv/glcd_dcs_queue.sv */
// Short plan queue between the front end and the bus emitter.
// Depends on glcd_dcs_pkg.
`default_nettype none

module glcd_dcs_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire glcd_dcs_pkg::plan_t  push_plan,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output glcd_dcs_pkg::plan_t       head_plan
);

  localparam int DEPTH = glcd_dcs_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  glcd_dcs_pkg::plan_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_plan  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_plan;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/glcd_dcs_back.sv */
// Bus emitter: walks plans to an output register, one transaction per unstalled cycle.
// Depends on glcd_dcs_pkg.
`default_nettype none

module glcd_dcs_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 head_valid,
  input  wire glcd_dcs_pkg::plan_t  head_plan,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                bus_kind,
  output logic                      chip,
  output logic [7:0]                bus_byte,
  output logic                      last
);

  logic [1:0]           idx;
  logic                 load;
  logic                 final_one;
  glcd_dcs_pkg::trans_t cur;

  assign load      = !out_valid || out_ready;
  assign cur       = head_plan.ent[idx];
  assign final_one = ({1'b0, idx} + 3'd1) >= head_plan.cnt;
  assign pop       = load && head_valid && final_one;

  // Transaction index within the head plan
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= final_one ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      bus_kind <= cur.kind;
      chip     <= cur.chip;
      bus_byte <= cur.data;
      last     <= final_one;
    end
  end

endmodule

`default_nettype wire

/* sv/glcd_dual_chip_cursor_sequencer_unit.sv */
// Top level of the dual-controller graphic LCD cursor sequencer: APB registers and datapath.
// Depends on glcd_dcs_pkg, glcd_dcs_front, glcd_dcs_queue, glcd_dcs_back.
//
//   port group   direction  handshake             payload
//   request      in         in_valid / in_ready   opcode, column, page, data_byte, chip_index
//   bus item     out        out_valid / out_ready bus_kind, chip, bus_byte, last
//   registers    in/out     APB psel/penable      paddr, pwdata, prdata
//
// Each request yields one to four bus items, emitted one per cycle from the
// output register unless stalled; the emitter works through one request at a time.
// The front end takes a request per cycle while the two-entry plan queue has room.
// Synchronous reset clears cursor, chip, page cache, queue and output valid.
// A stalled output holds its item; the queue lets the front keep accepting.
`default_nettype none

module glcd_dual_chip_cursor_sequencer_unit #(
  parameter int CHIP_COLUMNS = 64,
  parameter int PAGES        = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [6:0]  column,
  input  wire logic [2:0]  page,
  input  wire logic [7:0]  data_byte,
  input  wire logic        chip_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       bus_kind,
  output logic             chip,
  output logic [7:0]       bus_byte,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]          column_base;
  logic [7:0]          page_base;
  logic                q_full;
  logic                q_push;
  glcd_dcs_pkg::plan_t q_plan;
  logic                q_pop;
  logic                head_valid;
  glcd_dcs_pkg::plan_t head_plan;
  logic                cfg_write;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_base <= glcd_dcs_pkg::COLUMN_BASE_RESET;
      page_base   <= glcd_dcs_pkg::PAGE_BASE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == glcd_dcs_pkg::REG_COLUMN_BASE) begin
        column_base <= pwdata[7:0];
      end else begin
        page_base <= pwdata[7:0];
      end
    end
  end

  // Register readback
  always_comb begin
    if (paddr[2] == glcd_dcs_pkg::REG_PAGE_BASE) begin
      prdata = {24'd0, page_base};
    end else begin
      prdata = {24'd0, column_base};
    end
  end

  glcd_dcs_front #(
    .CHIP_COLUMNS (CHIP_COLUMNS),
    .PAGES        (PAGES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .column      (column),
    .page        (page),
    .data_byte   (data_byte),
    .chip_index  (chip_index),
    .column_base (column_base),
    .page_base   (page_base),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_plan      (q_plan)
  );

  glcd_dcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_plan  (q_plan),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_plan  (head_plan)
  );

  glcd_dcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_plan  (head_plan),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bus_kind   (bus_kind),
    .chip       (chip),
    .bus_byte   (bus_byte),
    .last       (last)
  );

endmodule

`default_nettype wire
